/* design/smw_pkg.sv */
// Shared types and constants for the SPI register writer.
package smw_pkg;

  localparam int unsigned DATA_BITS   = 8;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BITCNT_W    = $clog2(DATA_BITS + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0]     HALF_PERIOD_RST   = 16'd128;
  localparam logic [DATA_BITS-1:0] WRITE_COMMAND_RST = 8'd32;
  localparam logic [DATA_BITS-1:0] REGISTER_MASK_RST = 8'd31;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_XCHG  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD   = 2'd0,
    CFG_WRITE_COMMAND = 2'd1,
    CFG_REGISTER_MASK = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_EXCHANGE = 4'b0010,
    PH_COMMAND  = 4'b0100,
    PH_DATA     = 4'b1000
  } phase_e;

  // Result of one tick: pin levels and status after the tick.
  typedef struct packed {
    logic                 rx_valid;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 busy_res;
    logic                 ss_n;
    logic                 mosi;
    logic                 sck;
  } res_t;

endpackage

/* design/smw_core.sv */
// Pin sequencer: configuration registers, divider, shifters and phase control.
module smw_core import smw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  step_i,
  input  logic [1:0]            req_type_i,
  input  logic [DATA_BITS-1:0]  tx_byte_i,
  input  logic [DATA_BITS-1:0]  reg_addr_i,
  input  logic                  miso_i,
  output res_t                  res_o
);

  logic [CNT_W-1:0]     half_period_q;
  logic [DATA_BITS-1:0] write_command_q, register_mask_q;

  logic                 sck_q, sck_d;
  logic                 clk_en_q, clk_en_d;
  logic [CNT_W-1:0]     tick_q, tick_d;
  logic [BITCNT_W-1:0]  bits_left_q, bits_left_d;
  logic [DATA_BITS-1:0] out_shift_q, out_shift_d;
  logic [DATA_BITS-1:0] in_shift_q, in_shift_d;
  logic [DATA_BITS-1:0] held_q, held_d;
  phase_e               phase_q, phase_d;
  logic                 sel_q, sel_d;
  logic [DATA_BITS-1:0] rx_hold_q, rx_hold_d;
  logic                 done;
  logic                 start;
  logic [CNT_W-1:0]     tick_inc;
  req_e                 req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q   <= HALF_PERIOD_RST;
      write_command_q <= WRITE_COMMAND_RST;
      register_mask_q <= REGISTER_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_PERIOD:   half_period_q   <= cfg_data_i;
        CFG_WRITE_COMMAND: write_command_q <= cfg_data_i[DATA_BITS-1:0];
        CFG_REGISTER_MASK: register_mask_q <= cfg_data_i[DATA_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign req      = req_e'(req_type_i);
  assign start    = (phase_q == PH_IDLE) && ((req == REQ_XCHG) || (req == REQ_WRITE));
  assign tick_inc = tick_q + CNT_W'(1);

  always_comb begin
    sck_d       = sck_q;
    clk_en_d    = clk_en_q;
    tick_d      = tick_q;
    bits_left_d = bits_left_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    held_d      = held_q;
    phase_d     = phase_q;
    sel_d       = sel_q;
    rx_hold_d   = rx_hold_q;
    done        = 1'b0;

    if (start) begin
      sck_d       = 1'b0;
      tick_d      = '0;
      clk_en_d    = 1'b1;
      bits_left_d = BITCNT_W'(DATA_BITS);
      in_shift_d  = '0;
      if (req == REQ_XCHG) begin
        out_shift_d = tx_byte_i;
        phase_d     = PH_EXCHANGE;
      end else begin
        out_shift_d = write_command_q | (register_mask_q & reg_addr_i);
        held_d      = tx_byte_i;
        sel_d       = 1'b0;
        phase_d     = PH_COMMAND;
      end
    end else if (clk_en_q) begin
      tick_d = tick_inc;
      if (tick_inc >= half_period_q) begin
        tick_d = '0;
        if (!sck_q) begin
          // rising edge: sample MISO
          sck_d      = 1'b1;
          in_shift_d = {in_shift_q[DATA_BITS-2:0], miso_i};
          if (bits_left_q != '0) bits_left_d = bits_left_q - BITCNT_W'(1);
        end else begin
          // falling edge: advance MOSI, chain the data byte or finish
          sck_d = 1'b0;
          if (bits_left_q != '0) begin
            out_shift_d = {out_shift_q[DATA_BITS-2:0], 1'b0};
          end else if (phase_q == PH_COMMAND) begin
            out_shift_d = held_q;
            bits_left_d = BITCNT_W'(DATA_BITS);
            in_shift_d  = '0;
            phase_d     = PH_DATA;
          end else begin
            rx_hold_d = in_shift_q;
            if (phase_q == PH_DATA) sel_d = 1'b1;
            phase_d  = PH_IDLE;
            clk_en_d = 1'b0;
            done     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sck_q       <= 1'b0;
      clk_en_q    <= 1'b0;
      tick_q      <= '0;
      bits_left_q <= '0;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      held_q      <= '0;
      phase_q     <= PH_IDLE;
      sel_q       <= 1'b1;
      rx_hold_q   <= '0;
    end else if (step_i) begin
      sck_q       <= sck_d;
      clk_en_q    <= clk_en_d;
      tick_q      <= tick_d;
      bits_left_q <= bits_left_d;
      out_shift_q <= out_shift_d;
      in_shift_q  <= in_shift_d;
      held_q      <= held_d;
      phase_q     <= phase_d;
      sel_q       <= sel_d;
      rx_hold_q   <= rx_hold_d;
    end
  end

  always_comb begin
    res_o.sck      = sck_d;
    res_o.mosi     = out_shift_d[DATA_BITS-1];
    res_o.ss_n     = sel_d;
    res_o.busy_res = (phase_d != PH_IDLE);
    res_o.rx_byte  = rx_hold_d;
    res_o.rx_valid = done;
  end

endmodule

/* design/smw_out_buf.sv */
// Two-entry result buffer: output register plus skid stage.
module smw_out_buf import smw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !pop) begin
      // output stalled: park a new request in the skid stage
      if (push_i) skid_valid_q <= 1'b1;
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !pop) begin
      if (push_i) skid_q <= data_i;
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= data_i;
    end
  end

endmodule

/* design/spi_master_register_writer.sv */
// Top level of the mode 0, MSB-first SPI master with register-write sequencing.
// Each request is one tick of the serial clock divider and pin sequencer. One request
// is taken every cycle while ready is high; its result (pin levels and status after
// that tick) is registered in the result buffer before the master side sees it. The
// two-entry buffer parks a result in its skid stage when the output stalls; slave-side
// ready drops only while both entries are full. Configuration writes are always taken.
module spi_master_register_writer import smw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // tx_byte[7:0], reg_addr[15:8], miso[16]
  input  logic [1:0]             s_axis_tuser,   // req_type[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // sck, mosi, ss_n, busy_res,
                                                 // rx_byte[11:4], rx_valid[12]
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic step;
  res_t res, res_out;

  assign cfg_ready_o = 1'b1;
  assign step        = s_axis_tvalid && s_axis_tready;

  smw_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .req_type_i (s_axis_tuser),
    .tx_byte_i  (s_axis_tdata[7:0]),
    .reg_addr_i (s_axis_tdata[15:8]),
    .miso_i     (s_axis_tdata[16]),
    .res_o      (res)
  );

  smw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .data_i      (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (res_out)
  );

  assign m_axis_tdata = {3'b000, res_out.rx_valid, res_out.rx_byte, res_out.busy_res,
                         res_out.ss_n, res_out.mosi, res_out.sck};

endmodule

/* bench/tb_spi_master_register_writer.sv */
// Self-checking bench for the mode 0 SPI master with register-write sequencing.
`timescale 1ns / 1ps

module tb_spi_master_register_writer;
  import smw_pkg::*;

  typedef struct packed {
    req_e                 req;
    logic [7:0]           tx;
    logic [7:0]           addr;
    logic                 miso;
  } tick_t;

  localparam int unsigned HOLD_AT   = 230;
  localparam int unsigned HOLD_LEN  = 48;
  localparam int unsigned MAX_SHOWN = 10;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // tx_byte, reg_addr, miso, zero fill
  logic [1:0]             s_axis_tuser = REQ_TICK; // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // sck, mosi, ss_n, busy_res, rx_byte,
                                                // rx_valid, zero fill
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  spi_master_register_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pin model state and its copy of the registers
  logic [15:0] hp_cfg;
  logic [7:0]  wcmd_cfg;
  logic [7:0]  mask_cfg;
  logic        sck_lvl;
  logic        clk_en;
  logic [15:0] tick_cnt;
  logic [3:0]  bits_left;
  logic [7:0]  out_sr;
  logic [7:0]  in_sr;
  logic [7:0]  held_byte;
  phase_e      seq_phase;
  logic        sel_lvl;
  logic [7:0]  rx_last;

  tick_t       pending_q[$];
  res_t        pin_state_q[$];
  tick_t       offered;
  res_t        seen_pins;
  res_t        want_pins;
  int unsigned fail_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet = 1'b0;

  function automatic void load_byte(logic [7:0] value);
    out_sr    = value;
    bits_left = 4'd8;
    in_sr     = 8'h00;
  endfunction

  // Advance the pin sequencer by one tick and return the pins after it.
  function automatic res_t advance_pins(tick_t t);
    res_t r;
    logic done;
    done = 1'b0;
    if (seq_phase == PH_IDLE && (t.req == REQ_XCHG || t.req == REQ_WRITE)) begin
      sck_lvl  = 1'b0;
      tick_cnt = 16'd0;
      clk_en   = 1'b1;
      if (t.req == REQ_XCHG) begin
        load_byte(t.tx);
        seq_phase = PH_EXCHANGE;
      end else begin
        load_byte(wcmd_cfg | (mask_cfg & t.addr));
        held_byte = t.tx;
        sel_lvl   = 1'b0;
        seq_phase = PH_COMMAND;
      end
    end else if (clk_en) begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= hp_cfg) begin
        tick_cnt = 16'd0;
        if (!sck_lvl) begin
          sck_lvl = 1'b1;
          in_sr   = {in_sr[6:0], t.miso};
          if (bits_left != 4'd0)
            bits_left = bits_left - 4'd1;
        end else begin
          sck_lvl = 1'b0;
          if (bits_left != 4'd0) begin
            out_sr = {out_sr[6:0], 1'b0};
          end else if (seq_phase == PH_COMMAND) begin
            // data byte follows the command byte with no pause
            load_byte(held_byte);
            seq_phase = PH_DATA;
          end else begin
            rx_last = in_sr;
            if (seq_phase == PH_DATA)
              sel_lvl = 1'b1;
            seq_phase = PH_IDLE;
            clk_en    = 1'b0;
            tick_cnt  = 16'd0;
            done      = 1'b1;
          end
        end
      end
    end
    r.sck      = sck_lvl;
    r.mosi     = out_sr[7];
    r.ss_n     = sel_lvl;
    r.busy_res = (seq_phase != PH_IDLE);
    r.rx_byte  = rx_last;
    r.rx_valid = done;
    return r;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int unsigned pick;
    pick   = $urandom_range(0, 15);
    t.req  = (pick < 10) ? REQ_TICK : (pick < 12) ? REQ_XCHG :
             (pick < 14) ? REQ_WRITE : REQ_RSVD;
    t.tx   = 8'($urandom_range(0, 255));
    t.addr = 8'($urandom_range(0, 255));
    t.miso = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic add_tick(req_e r, logic [7:0] tx, logic [7:0] addr, logic miso);
    tick_t t;
    t.req  = r;
    t.tx   = tx;
    t.addr = addr;
    t.miso = miso;
    pending_q.push_back(t);
  endtask

  task automatic drain_results();
    do
      @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || pin_state_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do
      @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_HALF_PERIOD:   hp_cfg   = val;
      CFG_WRITE_COMMAND: wcmd_cfg = val[7:0];
      CFG_REGISTER_MASK: mask_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) pending_q.push_back(rand_tick());
    drain_results();
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= REQ_TICK;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pin_state_q.push_back(advance_pins(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!quiet && send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          offered = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, offered.miso, offered.addr, offered.tx};
          s_axis_tuser  <= offered.req;
          if (!quiet && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 16);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall  = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_pins = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        results_seen++;
        if (pin_state_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("unexpected result %h at %0t", seen_pins, $realtime);
        end else begin
          want_pins = pin_state_q.pop_front();
          if (seen_pins.sck !== want_pins.sck || seen_pins.mosi !== want_pins.mosi ||
              seen_pins.ss_n !== want_pins.ss_n ||
              seen_pins.busy_res !== want_pins.busy_res ||
              seen_pins.rx_byte !== want_pins.rx_byte ||
              seen_pins.rx_valid !== want_pins.rx_valid) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN)
              $display("mismatch at result %0d: exp sck=%b mosi=%b ss_n=%b busy=%b rx=%h vld=%b",
                       results_seen, want_pins.sck, want_pins.mosi, want_pins.ss_n,
                       want_pins.busy_res, want_pins.rx_byte, want_pins.rx_valid,
                       "\n  got sck=%b mosi=%b ss_n=%b busy=%b rx=%h vld=%b",
                       seen_pins.sck, seen_pins.mosi, seen_pins.ss_n,
                       seen_pins.busy_res, seen_pins.rx_byte, seen_pins.rx_valid);
          end
        end
      end
      // hold off once for a long stretch so the block backs up its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && rx_stall != 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0)
          rx_stall = $urandom_range(1, 16);
      end
    end
  end

  initial begin
    hp_cfg    = HALF_PERIOD_RST;
    wcmd_cfg  = WRITE_COMMAND_RST;
    mask_cfg  = REGISTER_MASK_RST;
    sck_lvl   = 1'b0;
    clk_en    = 1'b0;
    tick_cnt  = 16'd0;
    bits_left = 4'd0;
    out_sr    = 8'h00;
    in_sr     = 8'h00;
    held_byte = 8'h00;
    seq_phase = PH_IDLE;
    sel_lvl   = 1'b1;
    rx_last   = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: plain ticks, unused code, exchange, requests while busy
    add_tick(REQ_TICK, 8'hFF, 8'hFF, 1'b1);
    add_tick(REQ_RSVD, 8'h00, 8'h00, 1'b0);
    add_tick(REQ_XCHG, 8'hA5, 8'h3C, 1'b1);
    add_tick(REQ_WRITE, 8'h5A, 8'hC3, 1'b0);
    add_tick(REQ_XCHG, 8'hFF, 8'hFF, 1'b1);
    add_tick(REQ_RSVD, 8'hFF, 8'hFF, 1'b1);
    drain_results();

    // Zero divider while the exchange is mid-count
    write_reg(CFG_HALF_PERIOD, 16'd0);
    write_reg(CFG_WRITE_COMMAND, 16'h00FF);
    write_reg(CFG_REGISTER_MASK, 16'h0000);
    write_reg(CFG_UNUSED, 16'hFFFF);
    repeat (18) add_tick(REQ_TICK, 8'h00, 8'h00, 1'($urandom_range(0, 1)));
    add_tick(REQ_WRITE, 8'h00, 8'hFF, 1'b1);
    repeat (36) add_tick(REQ_TICK, 8'hFF, 8'h00, 1'($urandom_range(0, 1)));
    add_tick(REQ_XCHG, 8'h00, 8'hFF, 1'b0);
    drain_results();

    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_WRITE_COMMAND, 16'h0000);
    write_reg(CFG_REGISTER_MASK, 16'h00FF);
    run_random(70);

    // Slowest divider: start a write and leave it mid-count
    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    write_reg(CFG_WRITE_COMMAND, 16'($urandom_range(0, 255)));
    write_reg(CFG_REGISTER_MASK, 16'($urandom_range(0, 255)));
    drain_results();
    run_random(4);
    add_tick(REQ_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    run_random(8);

    write_reg(CFG_HALF_PERIOD, 16'd2);
    write_reg(CFG_REGISTER_MASK, 16'($urandom_range(0, 255)));
    run_random(120);

    write_reg(CFG_HALF_PERIOD, 16'd3);
    write_reg(CFG_WRITE_COMMAND, 16'h00FF);
    write_reg(CFG_REGISTER_MASK, 16'h00FF);
    run_random(70);

    // Final stretch runs at full rate on both sides
    @(negedge clk_i);
    quiet = 1'b1;
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_WRITE_COMMAND, 16'($urandom_range(0, 255)));
    run_random(80);

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* spi_master_register_writer.f */
design/smw_pkg.sv
design/smw_core.sv
design/smw_out_buf.sv
design/spi_master_register_writer.sv
bench/tb_spi_master_register_writer.sv
